[design/qltu_pkg.sv]
// ----------------------------------------------------------------------------
// qltu_pkg: shared types and constants of the Q table update block
// Transfer formats, operation and status codes, register indexes, defaults.
// ----------------------------------------------------------------------------
package qltu_pkg;

  localparam int NUM_STATES_DEF  = 256;
  localparam int NUM_ACTIONS_DEF = 8;
  localparam int MAX_RESULTS     = 8;
  localparam int CNT_W           = 4;   // holds 0..MAX_RESULTS

  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [16:0] LR_RESET    = 17'd6554;
  localparam logic [16:0] DISC_RESET  = 17'd58982;
  localparam logic [16:0] STEP_RESET  = 17'd66;

  localparam logic [1:0] MODE_DECLARE = 2'd0;
  localparam logic [1:0] MODE_UPDATE  = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNDECL   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  localparam logic [1:0] REG_LR      = 2'd0;
  localparam logic [1:0] REG_DISC    = 2'd1;
  localparam logic [1:0] REG_STEP    = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         state_sel;
    logic [2:0]         action_sel;
    logic [7:0]         next_state;
    logic signed [31:0] reward;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         action_out;
    logic signed [31:0] q_out;
    logic [31:0]        confidence_out;
    logic               last;
  } out_t;

  // table port strobes
  typedef struct packed {
    logic ent_rd;
    logic ent_wr;
    logic row_rd;
    logic row_wr;
  } tbl_ctl_t;

endpackage

[design/qltu_mul.sv]
// ----------------------------------------------------------------------------
// qltu_mul: shared registered multiplier
// 18x34 signed product, captured when enabled.
// ----------------------------------------------------------------------------
module qltu_mul (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [17:0]  op_a_i,
  input  logic signed [33:0]  op_b_i,
  output logic signed [51:0]  prod_o
);
  logic signed [51:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= op_a_i * op_b_i;
    end
  end

  assign prod_o = prod_q;
endmodule

[design/qltu_table.sv]
// ----------------------------------------------------------------------------
// qltu_table: Q table storage
// Value and confidence memories per entry, valid bits per state row, and the
// row clearing sweep after reset.
// ----------------------------------------------------------------------------
module qltu_table #(
  parameter int NUM_STATES  = qltu_pkg::NUM_STATES_DEF,
  parameter int NUM_ACTIONS = qltu_pkg::NUM_ACTIONS_DEF,
  localparam int ENTRIES    = NUM_STATES * NUM_ACTIONS,
  localparam int EW         = $clog2(ENTRIES),
  localparam int SW         = $clog2(NUM_STATES)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  qltu_pkg::tbl_ctl_t      ctl_i,
  input  logic [EW-1:0]           ent_addr_i,
  input  logic [31:0]             q_wdata_i,
  input  logic [31:0]             c_wdata_i,
  input  logic [SW-1:0]           row_addr_i,
  input  logic [NUM_ACTIONS-1:0]  row_wdata_i,
  output logic [31:0]             q_rdata_o,
  output logic [31:0]             c_rdata_o,
  output logic [NUM_ACTIONS-1:0]  row_rdata_o,
  output logic                    clr_busy_o
);
  import qltu_pkg::*;

  logic [31:0]            q_mem [ENTRIES];
  logic [31:0]            c_mem [ENTRIES];
  logic [NUM_ACTIONS-1:0] v_mem [NUM_STATES];

  logic [31:0]            q_rd_q, c_rd_q;
  logic [NUM_ACTIONS-1:0] row_rd_q;
  logic [SW-1:0]          clr_q;
  logic                   busy_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ent_wr) begin
      q_mem[ent_addr_i] <= q_wdata_i;
      c_mem[ent_addr_i] <= c_wdata_i;
    end
    if (ctl_i.ent_rd) begin
      q_rd_q <= q_mem[ent_addr_i];
      c_rd_q <= c_mem[ent_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      v_mem[clr_q] <= '0;
    end else if (ctl_i.row_wr) begin
      v_mem[row_addr_i] <= row_wdata_i;
    end
    if (ctl_i.row_rd) begin
      row_rd_q <= v_mem[row_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (clr_q == SW'(NUM_STATES - 1)) begin
        busy_q <= 1'b0;
      end
      clr_q <= clr_q + 1'b1;
    end
  end

  assign q_rdata_o   = q_rd_q;
  assign c_rdata_o   = c_rd_q;
  assign row_rdata_o = row_rd_q;
  assign clr_busy_o  = busy_q;
endmodule

[design/q_learning_table_update.sv]
// ----------------------------------------------------------------------------
// q_learning_table_update: tabular Q-learning entry update engine
// Declares, updates and lists entries of a state by action Q table.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (valid/ready): one request per transfer (declare, update,
//   query). in_ready_o is high only while the engine is idle; one request is
//   worked at a time by a small sequencer around one shared multiplier.
//   out channel (valid/ready): one result register. Declare and update give
//   one result; query gives one per valid slot (at most MAX_RESULTS) or one
//   ST_EMPTY result, last marking the final one. A stalled receiver simply holds
//   the sequencer at the cycle that would load the result register.
//   Work per request, set by single ported table reads and the multiplier:
//     declare or rejected request: state row read, decode, then result
//     update: one next-state read per slot for the maximum, then three
//       multiplies through the shared unit
//     query: state row read, then a slot scan with one entry read per result
//   Reset: config registers take their defaults; the valid bits are cleared
//   by a sweep over all NUM_STATES rows, one state row a cycle, during which no
//   request is taken (APB writes still land).
//   Configuration via APB, registers at 0x0, 0x4, 0x8; pready always high.
// ----------------------------------------------------------------------------
module q_learning_table_update #(
  parameter int NUM_STATES  = qltu_pkg::NUM_STATES_DEF,
  parameter int NUM_ACTIONS = qltu_pkg::NUM_ACTIONS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  qltu_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output qltu_pkg::out_t  out_data_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import qltu_pkg::*;

  localparam int ENTRIES = NUM_STATES * NUM_ACTIONS;
  localparam int EW      = $clog2(ENTRIES);
  localparam int SW      = $clog2(NUM_STATES);
  localparam int AW      = $clog2(NUM_ACTIONS);
  localparam int JW      = $clog2(NUM_ACTIONS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_NROW  = 4'd3;
  localparam logic [3:0] S_MAX   = 4'd4;
  localparam logic [3:0] S_RDQ   = 4'd5;
  localparam logic [3:0] S_M1    = 4'd6;
  localparam logic [3:0] S_M2    = 4'd7;
  localparam logic [3:0] S_M3    = 4'd8;
  localparam logic [3:0] S_M4    = 4'd9;
  localparam logic [3:0] S_RESP  = 4'd10;
  localparam logic [3:0] S_QSCAN = 4'd11;
  localparam logic [3:0] S_QEMIT = 4'd12;

  // ---------------- configuration ----------------
  logic [16:0] lr_q, disc_q, step_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q   <= LR_RESET;
      disc_q <= DISC_RESET;
      step_q <= STEP_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LR:   lr_q   <= pwdata[16:0];
        REG_DISC: disc_q <= pwdata[16:0];
        REG_STEP: step_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LR:   prdata = {15'd0, lr_q};
      REG_DISC: prdata = {15'd0, disc_q};
      REG_STEP: prdata = {15'd0, step_q};
      default:  prdata = '0;
    endcase
  end

  // alpha and gamma clamp at 1.0
  logic [16:0] alpha, gamma;
  assign alpha = (lr_q > ONE_Q16) ? ONE_Q16 : lr_q;
  assign gamma = (disc_q > ONE_Q16) ? ONE_Q16 : disc_q;

  // ---------------- sequencer state ----------------
  logic [3:0]  state_q, state_d;
  in_t         req_q;
  logic [JW-1:0]          cnt_q, cnt_d;
  logic [CNT_W-1:0]       n_q, n_d;
  logic [NUM_ACTIONS-1:0] row_q, row_d;
  logic signed [31:0]     mx_q, mx_d;
  logic signed [33:0]     t_q, t_d;
  logic signed [51:0]     acc_q, acc_d;
  logic [1:0]             rstat_q, rstat_d;
  logic [2:0]             ract_q, ract_d;

  logic    ov_q;
  out_t    out_q;
  logic    out_ld;
  out_t    out_nx;
  logic    out_free;

  // table port
  tbl_ctl_t               tctl;
  logic [EW-1:0]          ent_addr;
  logic [31:0]            q_wdata, c_wdata;
  logic [SW-1:0]          row_addr;
  logic [NUM_ACTIONS-1:0] row_wdata;
  logic [31:0]            q_rdata, c_rdata;
  logic [NUM_ACTIONS-1:0] row_rdata;
  logic                   clr_busy;

  // multiplier
  logic               mul_en;
  logic signed [17:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [51:0] prod;

  qltu_table #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (tctl),
    .ent_addr_i  (ent_addr),
    .q_wdata_i   (q_wdata),
    .c_wdata_i   (c_wdata),
    .row_addr_i  (row_addr),
    .row_wdata_i (row_wdata),
    .q_rdata_o   (q_rdata),
    .c_rdata_o   (c_rdata),
    .row_rdata_o (row_rdata),
    .clr_busy_o  (clr_busy)
  );

  qltu_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  // ---------------- request decode ----------------
  logic          st_inr, nx_inr, act_inr, inr;
  logic [EW-1:0] st_base, nx_base, idx;
  logic [AW-1:0] act_ix, cnt_ix, cntm1_ix;

  assign st_inr  = {24'd0, req_q.state_sel} < 32'(NUM_STATES);
  assign nx_inr  = {24'd0, req_q.next_state} < 32'(NUM_STATES);
  assign act_inr = {29'd0, req_q.action_sel} < 32'(NUM_ACTIONS);
  assign inr     = st_inr && act_inr;
  // out-of-range ids only ever reach here with their result masked off
  assign st_base = EW'(req_q.state_sel) * EW'(NUM_ACTIONS);
  assign nx_base = EW'(req_q.next_state) * EW'(NUM_ACTIONS);
  assign act_ix  = AW'(req_q.action_sel);
  assign idx     = st_base + EW'(req_q.action_sel);
  assign cnt_ix  = AW'(cnt_q);
  assign cntm1_ix = AW'(cnt_q - 1'b1);

  // any valid slot left beyond the current one
  logic more;
  always_comb begin
    more = 1'b0;
    for (int k = 0; k < NUM_ACTIONS; k++) begin
      if (row_q[k] && (JW'(k) > cnt_q)) more = 1'b1;
    end
  end

  // update arithmetic on registered operands
  logic signed [52:0] sum;
  logic signed [36:0] nv;
  logic signed [31:0] nv_sat;
  logic [32:0]        nc;
  logic [31:0]        nc_sat;

  assign sum    = 53'(acc_q) + 53'(prod);
  assign nv     = 37'(sum >>> 16);
  assign nv_sat = (nv > 37'sd2147483647)  ? 32'sh7FFFFFFF :
                  (nv < -37'sd2147483648) ? 32'sh80000000 : nv[31:0];
  assign nc     = {1'b0, c_rdata} + {16'd0, step_q};
  assign nc_sat = nc[32] ? 32'hFFFFFFFF : nc[31:0];

  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && !clr_busy;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    row_d     = row_q;
    mx_d      = mx_q;
    t_d       = t_q;
    acc_d     = acc_q;
    rstat_d   = rstat_q;
    ract_d    = ract_q;
    tctl      = '0;
    ent_addr  = idx;
    q_wdata   = '0;
    c_wdata   = '0;
    row_addr  = SW'(req_q.state_sel);
    row_wdata = row_rdata;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    out_ld    = 1'b0;
    out_nx    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) state_d = S_RD;
      end
      S_RD: begin
        tctl.row_rd = 1'b1;
        state_d     = S_DEC;
      end
      S_DEC: begin
        ract_d = req_q.action_sel;
        case (req_q.mode)
          MODE_DECLARE: begin
            if (inr) begin
              tctl.ent_wr       = 1'b1;
              tctl.row_wr       = 1'b1;
              row_wdata[act_ix] = 1'b1;
              rstat_d           = ST_OK;
            end else begin
              rstat_d = ST_UNDECL;
            end
            state_d = S_RESP;
          end
          MODE_UPDATE: begin
            if (inr && row_rdata[act_ix]) begin
              tctl.row_rd = 1'b1;
              row_addr    = SW'(req_q.next_state);
              state_d     = S_NROW;
            end else begin
              rstat_d = ST_UNDECL;
              state_d = S_RESP;
            end
          end
          MODE_QUERY: begin
            row_d = st_inr ? row_rdata : '0;
            cnt_d = '0;
            n_d   = '0;
            if (!st_inr || (row_rdata == '0)) begin
              rstat_d = ST_EMPTY;
              ract_d  = '0;
              state_d = S_RESP;
            end else begin
              state_d = S_QSCAN;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_NROW: begin
        row_d   = nx_inr ? row_rdata : '0;
        mx_d    = '0;
        cnt_d   = '0;
        state_d = S_MAX;
      end
      // one next-state slot read per cycle, the compare works on the slot read before
      S_MAX: begin
        if (cnt_q != JW'(NUM_ACTIONS)) begin
          tctl.ent_rd = 1'b1;
          ent_addr    = nx_base + EW'(cnt_q);
        end
        if ((cnt_q != '0) && row_q[cntm1_ix] && ($signed(q_rdata) > mx_q)) begin
          mx_d = $signed(q_rdata);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == JW'(NUM_ACTIONS)) state_d = S_RDQ;
      end
      S_RDQ: begin
        tctl.ent_rd = 1'b1;
        state_d     = S_M1;
      end
      S_M1: begin
        mul_en  = 1'b1;
        mul_a   = $signed({1'b0, gamma});
        mul_b   = 34'(mx_q);
        state_d = S_M2;
      end
      S_M2: begin
        t_d     = 34'(req_q.reward) + 34'(prod >>> 16);
        mul_en  = 1'b1;
        mul_a   = $signed({1'b0, ONE_Q16 - alpha});
        mul_b   = 34'($signed(q_rdata));
        state_d = S_M3;
      end
      S_M3: begin
        acc_d   = prod;
        mul_en  = 1'b1;
        mul_a   = $signed({1'b0, alpha});
        mul_b   = t_q;
        state_d = S_M4;
      end
      S_M4: begin
        if (out_free) begin
          tctl.ent_wr = 1'b1;
          q_wdata     = nv_sat;
          c_wdata     = nc_sat;
          out_ld      = 1'b1;
          out_nx      = '{status: ST_OK, action_out: req_q.action_sel,
                          q_out: nv_sat, confidence_out: nc_sat, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_ld  = 1'b1;
          out_nx  = '{status: rstat_q, action_out: ract_q,
                      q_out: '0, confidence_out: '0, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_QSCAN: begin
        if ((cnt_q == JW'(NUM_ACTIONS)) || (n_q == CNT_W'(MAX_RESULTS))) begin
          state_d = S_IDLE;
        end else if (row_q[cnt_ix]) begin
          tctl.ent_rd = 1'b1;
          ent_addr    = st_base + EW'(cnt_q);
          state_d     = S_QEMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_QEMIT: begin
        if (out_free) begin
          out_ld  = 1'b1;
          out_nx  = '{status: ST_OK, action_out: 3'(cnt_q),
                      q_out: $signed(q_rdata), confidence_out: c_rdata,
                      last: !(more && (n_q + 1'b1 < CNT_W'(MAX_RESULTS)))};
          n_d     = n_q + 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = out_nx.last ? S_IDLE : S_QSCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      if (out_ld) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
    row_q   <= row_d;
    mx_q    <= mx_d;
    t_q     <= t_d;
    acc_q   <= acc_d;
    rstat_q <= rstat_d;
    ract_q  <= ract_d;
    if (out_ld) out_q <= out_nx;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
endmodule
